[design/ibmw_pkg.sv]
// ----------------------------------------------------------------------------
// ibmw_pkg: shared types and constants for the indirect block map walker
// Field widths, command codes and the front-to-back command record.
// ----------------------------------------------------------------------------
`default_nettype none

package ibmw_pkg;

  localparam int DIRECT_COUNT  = 12;
  localparam int MAX_LOG_BLOCK = 6;
  localparam int QUEUE_DEPTH   = 4;

  localparam int PTR_W        = 32;
  localparam int ADDR_W       = 48;
  localparam int FB_W         = 64;
  localparam int LOG_W        = 3;
  localparam int PTR_LOG_BASE = 8;   // pointers per 1 KiB block, log2
  localparam int BLK_LOG_BASE = 10;  // bytes per 1 KiB block, log2

  localparam logic REG_LOG_BLOCK_SIZE = 1'b0;
  localparam logic REG_VOLUME_BLOCKS  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_REPLY   = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_REQUEST = 2'd0,
    ST_MAPPED  = 2'd1,
    ST_HOLE    = 2'd2,
    ST_ERROR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_NOP    = 3'd0,
    K_LOAD   = 3'd1,
    K_DIRECT = 3'd2,
    K_WALK   = 3'd3,
    K_ERROR  = 3'd4,
    K_REPLY  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] levels;
  } cmd_t;

  typedef struct packed {
    logic [LOG_W-1:0] log_blk;     // already clamped
    logic [PTR_W-1:0] vol_blocks;
  } cfg_t;

endpackage

`default_nettype wire

[design/indirect_block_map_walker.sv]
// ----------------------------------------------------------------------------
// indirect_block_map_walker: file block to disk block translation
// Direct and single/double/triple indirect lookup, one level per reply.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                        tuser
// in_      in   slot, pointer_value, file_block, reply_word  action
// out_     out  read_address, disk_block                     status
// cfg_     in   write enable / index / data, no read-back    -
//
// One item per cycle sustained while out_ is not stalled; an item is
// classified into the queue on acceptance and later reaches the result register.
// in_tready drops only when the 4-entry command queue is full.
// A stalled out_ channel holds the back end; the queue keeps absorbing items.
// Synchronous reset clears the pointer table, walk state and queue at once.
// ----------------------------------------------------------------------------
`default_nettype none

module indirect_block_map_walker #(
  parameter int DIRECT_COUNT  = ibmw_pkg::DIRECT_COUNT,
  parameter int MAX_LOG_BLOCK = ibmw_pkg::MAX_LOG_BLOCK
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire [31:0]   cfg_wdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire [135:0]  in_tdata,   // slot, pointer_value, file_block, reply_word, pad
  input  wire [1:0]    in_tuser,   // action
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [79:0]  out_tdata,  // read_address, disk_block
  output logic [1:0]   out_tuser   // status
);

  localparam int TBL  = DIRECT_COUNT + 3;
  localparam int TW   = $clog2(TBL);
  localparam int PMAX = ibmw_pkg::PTR_LOG_BASE + MAX_LOG_BLOCK;
  localparam int AW   = (3 * PMAX > ibmw_pkg::PTR_W) ? 3 * PMAX : ibmw_pkg::PTR_W;

  ibmw_pkg::cfg_t  cfg;
  ibmw_pkg::cmd_t  push_cmd, q_cmd;
  logic            push, pop, q_valid, not_full;
  logic [TW-1:0]   push_tix, q_tix;
  logic [AW-1:0]   push_arg, q_arg;
  logic [1:0]      out_status;
  logic [47:0]     out_read_address;
  logic [31:0]     out_disk_block;

  assign in_tready = not_full;

  ibmw_front #(
    .DIRECT_COUNT  (DIRECT_COUNT),
    .MAX_LOG_BLOCK (MAX_LOG_BLOCK),
    .TW            (TW),
    .AW            (AW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cfg_o            (cfg),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_action        (in_tuser),
    .in_slot          (in_tdata[3:0]),
    .in_pointer_value (in_tdata[35:4]),
    .in_file_block    (in_tdata[99:36]),
    .in_reply_word    (in_tdata[131:100]),
    .push             (push),
    .push_cmd         (push_cmd),
    .push_tix         (push_tix),
    .push_arg         (push_arg)
  );

  ibmw_queue #(
    .DEPTH (ibmw_pkg::QUEUE_DEPTH),
    .TW    (TW),
    .AW    (AW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .push_tix (push_tix),
    .push_arg (push_arg),
    .not_full (not_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_tix    (q_tix),
    .q_arg    (q_arg)
  );

  ibmw_back #(
    .DIRECT_COUNT  (DIRECT_COUNT),
    .MAX_LOG_BLOCK (MAX_LOG_BLOCK),
    .TW            (TW),
    .AW            (AW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_tix            (q_tix),
    .q_arg            (q_arg),
    .pop              (pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (out_status),
    .out_read_address (out_read_address),
    .out_disk_block   (out_disk_block)
  );

  assign out_tuser = out_status;
  assign out_tdata = {out_disk_block, out_read_address};

endmodule

`default_nettype wire

[design/ibmw_front.sv]
// ----------------------------------------------------------------------------
// ibmw_front: configuration registers and item classification
// Decodes each item, picks the walk depth and rebases the file block index.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmw_front #(
  parameter int DIRECT_COUNT  = ibmw_pkg::DIRECT_COUNT,
  parameter int MAX_LOG_BLOCK = ibmw_pkg::MAX_LOG_BLOCK,
  parameter int TW            = 4,
  parameter int AW            = 42
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [ibmw_pkg::PTR_W-1:0]    cfg_wdata,
  output ibmw_pkg::cfg_t               cfg_o,
  input  wire                          in_tvalid,
  input  wire                          in_tready,
  input  wire [1:0]                    in_action,
  input  wire [3:0]                    in_slot,
  input  wire [ibmw_pkg::PTR_W-1:0]    in_pointer_value,
  input  wire [ibmw_pkg::FB_W-1:0]     in_file_block,
  input  wire [ibmw_pkg::PTR_W-1:0]    in_reply_word,
  output logic                         push,
  output ibmw_pkg::cmd_t               push_cmd,
  output logic [TW-1:0]                push_tix,
  output logic [AW-1:0]                push_arg
);

  localparam int TBL  = DIRECT_COUNT + 3;
  localparam int PMAX = ibmw_pkg::PTR_LOG_BASE + MAX_LOG_BLOCK;
  localparam int IW   = 3 * PMAX;
  localparam int FB_W = ibmw_pkg::FB_W;

  logic [ibmw_pkg::LOG_W-1:0] log_r, log_nxt;
  logic [ibmw_pkg::PTR_W-1:0] vol_r, vol_nxt;
  logic [ibmw_pkg::LOG_W-1:0] lb;
  logic [3:0]                 p1;
  logic [4:0]                 p2;
  logic [5:0]                 p3;
  logic [FB_W-1:0]            lim1, lim2, lim3, off1, off2, off3, d1, d2, d3;

  always_comb begin
    log_nxt = log_r;
    vol_nxt = vol_r;
    if (cfg_we) begin
      case (cfg_index)
        ibmw_pkg::REG_LOG_BLOCK_SIZE: log_nxt = cfg_wdata[ibmw_pkg::LOG_W-1:0];
        ibmw_pkg::REG_VOLUME_BLOCKS:  vol_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r <= '0;
      vol_r <= '0;
    end else begin
      log_r <= log_nxt;
      vol_r <= vol_nxt;
    end
  end

  assign lb = (log_r > ibmw_pkg::LOG_W'(MAX_LOG_BLOCK)) ?
              ibmw_pkg::LOG_W'(MAX_LOG_BLOCK) : log_r;
  assign cfg_o.log_blk    = lb;
  assign cfg_o.vol_blocks = vol_r;

  assign p1 = 4'(ibmw_pkg::PTR_LOG_BASE) + 4'(lb);
  assign p2 = {p1, 1'b0};
  assign p3 = 6'(p2) + 6'(p1);

  // depth boundaries: DIRECT_COUNT is below any level span, so OR is an add
  assign lim1 = FB_W'(1) << p1;
  assign lim2 = FB_W'(1) << p2;
  assign lim3 = FB_W'(1) << p3;
  assign off1 = FB_W'(DIRECT_COUNT);
  assign off2 = off1 | lim1;
  assign off3 = off2 | lim2;
  assign d1   = in_file_block - off1;
  assign d2   = in_file_block - off2;
  assign d3   = in_file_block - off3;

  always_comb begin
    push_cmd.kind   = ibmw_pkg::K_NOP;
    push_cmd.levels = 2'd0;
    push_tix        = '0;
    push_arg        = '0;
    case (ibmw_pkg::act_t'(in_action))
      ibmw_pkg::ACT_LOAD: begin
        if (5'(in_slot) < 5'(TBL)) begin
          push_cmd.kind = ibmw_pkg::K_LOAD;
          push_tix      = TW'(in_slot);
          push_arg      = AW'(in_pointer_value);
        end
      end
      ibmw_pkg::ACT_RESOLVE: begin
        if (in_file_block < off1) begin
          push_cmd.kind = ibmw_pkg::K_DIRECT;
          push_tix      = TW'(in_file_block[4:0]);
        end else if (d1 < lim1) begin
          push_cmd.kind = ibmw_pkg::K_WALK;
          push_tix      = TW'(DIRECT_COUNT);
          push_arg      = AW'(d1[IW-1:0]);
        end else if (d2 < lim2) begin
          push_cmd.kind   = ibmw_pkg::K_WALK;
          push_cmd.levels = 2'd1;
          push_tix        = TW'(DIRECT_COUNT + 1);
          push_arg        = AW'(d2[IW-1:0]);
        end else if (d3 < lim3) begin
          push_cmd.kind   = ibmw_pkg::K_WALK;
          push_cmd.levels = 2'd2;
          push_tix        = TW'(DIRECT_COUNT + 2);
          push_arg        = AW'(d3[IW-1:0]);
        end else begin
          push_cmd.kind = ibmw_pkg::K_ERROR;
        end
      end
      ibmw_pkg::ACT_REPLY: begin
        push_cmd.kind = ibmw_pkg::K_REPLY;
        push_arg      = AW'(in_reply_word);
      end
      default: ;
    endcase
  end

  assign push = in_tvalid && in_tready && (push_cmd.kind != ibmw_pkg::K_NOP);

endmodule

`default_nettype wire

[design/ibmw_queue.sv]
// ----------------------------------------------------------------------------
// ibmw_queue: command queue between front and back
// Small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmw_queue #(
  parameter int DEPTH = ibmw_pkg::QUEUE_DEPTH,
  parameter int TW    = 4,
  parameter int AW    = 42
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  ibmw_pkg::cmd_t         push_cmd,
  input  wire [TW-1:0]           push_tix,
  input  wire [AW-1:0]           push_arg,
  output logic                   not_full,
  input  wire                    pop,
  output logic                   q_valid,
  output ibmw_pkg::cmd_t         q_cmd,
  output logic [TW-1:0]          q_tix,
  output logic [AW-1:0]          q_arg
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ibmw_pkg::cmd_t  cmd_mem [DEPTH];
  logic [TW-1:0]   tix_mem [DEPTH];
  logic [AW-1:0]   arg_mem [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign not_full = (cnt_r != CW'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign do_pop   = pop && q_valid;
  assign q_cmd    = cmd_mem[rptr_r];
  assign q_tix    = tix_mem[rptr_r];
  assign q_arg    = arg_mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wptr_r] <= push_cmd;
      tix_mem[wptr_r] <= push_tix;
      arg_mem[wptr_r] <= push_arg;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

[design/ibmw_back.sv]
// ----------------------------------------------------------------------------
// ibmw_back: pointer table, walk state and result register
// Executes queued commands one per cycle unless a stalled result holds it, and holds the outgoing result.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmw_back #(
  parameter int DIRECT_COUNT  = ibmw_pkg::DIRECT_COUNT,
  parameter int MAX_LOG_BLOCK = ibmw_pkg::MAX_LOG_BLOCK,
  parameter int TW            = 4,
  parameter int AW            = 42
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ibmw_pkg::cfg_t               cfg_i,
  input  wire                          q_valid,
  input  ibmw_pkg::cmd_t               q_cmd,
  input  wire [TW-1:0]                 q_tix,
  input  wire [AW-1:0]                 q_arg,
  output logic                         pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [1:0]                   out_status,
  output logic [ibmw_pkg::ADDR_W-1:0]  out_read_address,
  output logic [ibmw_pkg::PTR_W-1:0]   out_disk_block
);

  localparam int TBL    = DIRECT_COUNT + 3;
  localparam int PMAX   = ibmw_pkg::PTR_LOG_BASE + MAX_LOG_BLOCK;
  localparam int IW     = 3 * PMAX;
  localparam int RW     = 2 * PMAX;
  localparam int SW     = $clog2(2 * PMAX + 1);
  localparam int PTR_W  = ibmw_pkg::PTR_W;
  localparam int ADDR_W = ibmw_pkg::ADDR_W;

  logic [PTR_W-1:0]   table_r [TBL];
  logic [RW-1:0]      rem_r, rem_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  ibmw_pkg::status_t  out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [PTR_W-1:0]   out_disk_r;

  logic               fire;
  logic [PTR_W-1:0]   tbl_word, reply_w;
  logic               do_issue;
  logic [PTR_W-1:0]   iss_blk;
  logic [IW-1:0]      iss_idx, iss_shifted, iss_mask;
  logic [1:0]         iss_lvl;
  logic [3:0]         p1;
  logic [SW-1:0]      shamt;
  logic [4:0]         blk_sh;
  logic [ADDR_W-1:0]  iss_addr;
  logic               res_valid;
  ibmw_pkg::status_t  res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [PTR_W-1:0]   res_disk;

  assign fire     = q_valid && (!out_valid_r || out_tready);
  assign pop      = fire;
  assign tbl_word = table_r[q_tix];
  assign reply_w  = q_arg[PTR_W-1:0];
  assign p1       = 4'(ibmw_pkg::PTR_LOG_BASE) + 4'(cfg_i.log_blk);
  assign blk_sh   = 5'(ibmw_pkg::BLK_LOG_BASE) + 5'(cfg_i.log_blk);

  always_comb begin
    do_issue   = 1'b0;
    iss_blk    = '0;
    iss_idx    = '0;
    iss_lvl    = 2'd0;
    res_valid  = 1'b0;
    res_status = ibmw_pkg::ST_HOLE;
    res_addr   = '0;
    res_disk   = '0;
    busy_nxt   = busy_r;
    rem_nxt    = rem_r;
    lvl_nxt    = lvl_r;
    if (fire) begin
      case (q_cmd.kind)
        ibmw_pkg::K_DIRECT: begin
          busy_nxt   = 1'b0;
          res_valid  = 1'b1;
          res_status = (tbl_word == '0) ? ibmw_pkg::ST_HOLE : ibmw_pkg::ST_MAPPED;
          res_disk   = tbl_word;
        end
        ibmw_pkg::K_WALK: begin
          do_issue = 1'b1;
          iss_blk  = tbl_word;
          iss_idx  = q_arg[IW-1:0];
          iss_lvl  = q_cmd.levels;
        end
        ibmw_pkg::K_ERROR: begin
          busy_nxt   = 1'b0;
          res_valid  = 1'b1;
          res_status = ibmw_pkg::ST_ERROR;
        end
        ibmw_pkg::K_REPLY: begin
          if (busy_r) begin
            if (lvl_r == 2'd0) begin
              busy_nxt   = 1'b0;
              res_valid  = 1'b1;
              res_status = (reply_w == '0) ? ibmw_pkg::ST_HOLE : ibmw_pkg::ST_MAPPED;
              res_disk   = reply_w;
            end else begin
              do_issue = 1'b1;
              iss_blk  = reply_w;
              iss_idx  = IW'(rem_r);
              iss_lvl  = lvl_r - 2'd1;
            end
          end
        end
        default: ;
      endcase
    end

    case (iss_lvl)
      2'd1:    shamt = SW'(p1);
      2'd2:    shamt = SW'({p1, 1'b0});
      default: shamt = '0;
    endcase
    iss_shifted = iss_idx >> shamt;
    iss_mask    = ~({IW{1'b1}} << shamt);
    // entry offset stays below the block size, so the OR is the sum
    iss_addr    = (ADDR_W'(iss_blk) << blk_sh) |
                  (ADDR_W'(iss_shifted[PMAX-1:0]) << 2);

    if (do_issue) begin
      res_valid = 1'b1;
      busy_nxt  = 1'b0;
      if (iss_blk == '0) begin
        res_status = ibmw_pkg::ST_HOLE;
      end else if (iss_blk >= cfg_i.vol_blocks) begin
        res_status = ibmw_pkg::ST_ERROR;
      end else begin
        res_status = ibmw_pkg::ST_REQUEST;
        res_addr   = iss_addr;
        busy_nxt   = 1'b1;
        rem_nxt    = RW'(iss_idx & iss_mask);
        lvl_nxt    = iss_lvl;
      end
    end

    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL; i++) begin
        table_r[i] <= '0;
      end
      rem_r       <= '0;
      lvl_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && (q_cmd.kind == ibmw_pkg::K_LOAD)) begin
        table_r[q_tix] <= q_arg[PTR_W-1:0];
      end
      rem_r       <= rem_nxt;
      lvl_r       <= lvl_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_disk_r   <= res_disk;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_address = out_addr_r;
  assign out_disk_block   = out_disk_r;

`ifndef SYNTHESIS
  a_walk_starts_with_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> (out_valid_r && (out_status_r == ibmw_pkg::ST_REQUEST)))
    else $error("walk armed without a read request");

  a_idle_reply_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (q_cmd.kind == ibmw_pkg::K_REPLY) && !busy_r) |=> !out_valid_r)
    else $error("reply while idle produced an item");

  a_request_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ibmw_pkg::ST_REQUEST)) |->
      ((out_addr_r[1:0] == 2'b00) && (out_disk_r == '0)))
    else $error("request item malformed");

  a_answer_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ibmw_pkg::ST_REQUEST)) |-> (out_addr_r == '0))
    else $error("address on a final answer");
`endif

endmodule

`default_nettype wire

[sim/indirect_block_map_walker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indirect_block_map_walker_tb: self-checking bench for the block map walker
// Loads the pointer table, resolves direct and single/double/triple indirect
// file blocks and answers read requests with a pointer word. A local
// model of the walk predicts every answer; results are checked in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module indirect_block_map_walker_tb;

  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int          TABLE_SLOTS  = ibmw_pkg::DIRECT_COUNT + 3;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          LONG_HOLD    = 400;
  localparam int          PHASES       = 6;
  localparam int          RANDOM_ITEMS = 1020;
  localparam logic [63:0] FB_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [31:0] ptr_value;
    logic [63:0] file_block;
    logic [31:0] reply_word;
  } item_t;

  typedef struct packed {
    ibmw_pkg::status_t status;
    logic [47:0]       read_address;
    logic [31:0]       disk_block;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;   // slot, pointer_value, file_block, reply_word, pad
  logic [1:0]   in_tuser = '0;   // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;       // read_address, disk_block
  logic [1:0]   out_tuser;       // status

  // walk model state
  logic [31:0]  ptr_table [TABLE_SLOTS];
  logic [63:0]  rem_index;
  int unsigned  levels_left;
  bit           walk_busy;
  logic [2:0]   cur_log;
  logic [31:0]  cur_vol;

  answer_t      answers [$];
  int unsigned  error_count;
  int unsigned  useful_count;
  bit           long_hold_req;
  bit           tx_steady;
  bit           tx_noisy;
  int unsigned  tx_seg_left;

  indirect_block_map_walker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned clamped_log();
    return (cur_log > ibmw_pkg::MAX_LOG_BLOCK) ? ibmw_pkg::MAX_LOG_BLOCK : cur_log;
  endfunction

  function automatic void push_answer(ibmw_pkg::status_t st, logic [47:0] addr,
                                      logic [31:0] blk);
    answer_t a;
    a.status       = st;
    a.read_address = addr;
    a.disk_block   = blk;
    answers.push_back(a);
  endfunction

  function automatic void issue_level(logic [31:0] blk, logic [63:0] idx,
                                      int unsigned levels);
    int unsigned lb;
    int unsigned low;
    logic [63:0] addr;
    lb  = clamped_log();
    low = (8 + lb) * levels;
    walk_busy = 1'b0;
    if (blk == 32'd0) begin
      push_answer(ibmw_pkg::ST_HOLE, '0, '0);
    end else if (blk >= cur_vol) begin
      push_answer(ibmw_pkg::ST_ERROR, '0, '0);
    end else begin
      addr = ({32'd0, blk} << (10 + lb)) + ((idx >> low) << 2);
      rem_index   = idx & ((64'd1 << low) - 64'd1);
      levels_left = levels;
      walk_busy   = 1'b1;
      push_answer(ibmw_pkg::ST_REQUEST, addr[47:0], '0);
    end
  endfunction

  // returns 1 when the item is not simply ignored
  function automatic bit predict_item(item_t it);
    int unsigned p;
    int unsigned depth;
    logic [63:0] idx;
    logic [31:0] v;
    case (it.action)
      ibmw_pkg::ACT_LOAD: begin
        if (it.slot < TABLE_SLOTS) begin
          ptr_table[it.slot] = it.ptr_value;
          return 1'b1;
        end
        return 1'b0;
      end
      ibmw_pkg::ACT_RESOLVE: begin
        p = 8 + clamped_log();
        walk_busy = 1'b0;
        if (it.file_block < ibmw_pkg::DIRECT_COUNT) begin
          v = ptr_table[it.file_block[3:0]];
          push_answer((v == 32'd0) ? ibmw_pkg::ST_HOLE : ibmw_pkg::ST_MAPPED, '0, v);
          return 1'b1;
        end
        idx = it.file_block - ibmw_pkg::DIRECT_COUNT;
        if (idx < (64'd1 << p)) begin
          depth = 1;
        end else begin
          idx -= 64'd1 << p;
          if (idx < (64'd1 << (2 * p))) begin
            depth = 2;
          end else begin
            idx -= 64'd1 << (2 * p);
            if (idx < (64'd1 << (3 * p))) begin
              depth = 3;
            end else begin
              push_answer(ibmw_pkg::ST_ERROR, '0, '0);
              return 1'b1;
            end
          end
        end
        issue_level(ptr_table[ibmw_pkg::DIRECT_COUNT + depth - 1], idx, depth - 1);
        return 1'b1;
      end
      ibmw_pkg::ACT_REPLY: begin
        if (!walk_busy) return 1'b0;
        if (levels_left == 0) begin
          walk_busy = 1'b0;
          push_answer((it.reply_word == 32'd0) ? ibmw_pkg::ST_HOLE : ibmw_pkg::ST_MAPPED,
                      '0, it.reply_word);
        end else begin
          issue_level(it.reply_word, rem_index, levels_left - 1);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic int unsigned next_gap();
    if (tx_seg_left == 0) begin
      tx_noisy    = $urandom_range(0, 2) != 0;
      tx_seg_left = $urandom_range(20, 120);
    end
    tx_seg_left--;
    if (tx_steady || !tx_noisy || $urandom_range(0, 2) != 0) return 0;
    return pick_gap();
  endfunction

  function automatic item_t rand_item(logic [1:0] action);
    item_t it;
    it.action     = action;
    it.slot       = 4'($urandom);
    it.ptr_value  = $urandom;
    it.file_block = {$urandom, $urandom};
    it.reply_word = $urandom;
    return it;
  endfunction

  // pointer block number: mostly valid, sometimes zero or off the volume
  function automatic logic [31:0] ptr_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom;
    if (r == 2 && cur_vol != 32'd0) return $urandom_range(32'hFFFF_FFFF, cur_vol);
    if (cur_vol > 32'd1) return $urandom_range(cur_vol - 1, 1);
    return $urandom;
  endfunction

  function automatic logic [63:0] rand_bits(int unsigned n);
    logic [63:0] mask;
    int unsigned r;
    mask = (n >= 64) ? FB_MAX : ((64'd1 << n) - 64'd1);
    r = $urandom_range(0, 7);
    if (r == 0) return 64'd0;
    if (r == 1) return mask;
    return {$urandom, $urandom} & mask;
  endfunction

  // file block in the reach of a given depth (4 = beyond triple)
  function automatic logic [63:0] index_for_depth(int unsigned depth);
    int unsigned p;
    logic [63:0] base;
    logic [63:0] v;
    p = 8 + clamped_log();
    base = ibmw_pkg::DIRECT_COUNT;
    case (depth)
      0: return $urandom_range(0, ibmw_pkg::DIRECT_COUNT - 1);
      1: return base + rand_bits(p);
      2: return base + (64'd1 << p) + rand_bits(2 * p);
      3: return base + (64'd1 << p) + (64'd1 << (2 * p)) + rand_bits(3 * p);
      default: begin
        base += (64'd1 << p) + (64'd1 << (2 * p)) + (64'd1 << (3 * p));
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) v = base + rand_bits(16);
        if (v < base) v = FB_MAX - rand_bits(20);
        return v;
      end
    endcase
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {4'd0, it.reply_word, it.file_block, it.ptr_value, it.slot};
    do @(posedge clk); while (!in_tready);
    if (predict_item(it)) useful_count++;
  endtask

  task automatic send_load(input logic [3:0] slot, input logic [31:0] value);
    item_t it;
    it = rand_item(ibmw_pkg::ACT_LOAD);
    it.slot = slot;
    it.ptr_value = value;
    send_item(it);
  endtask

  task automatic send_resolve(input logic [63:0] fb);
    item_t it;
    it = rand_item(ibmw_pkg::ACT_RESOLVE);
    it.file_block = fb;
    send_item(it);
  endtask

  task automatic send_reply(input logic [31:0] word);
    item_t it;
    it = rand_item(ibmw_pkg::ACT_REPLY);
    it.reply_word = word;
    send_item(it);
  endtask

  // items the block ignores: unused action, bad slot, reply with no walk
  task automatic send_noise();
    item_t it;
    case ($urandom_range(0, 2))
      0: it = rand_item(ACT_UNUSED);
      1: begin
        it = rand_item(ibmw_pkg::ACT_LOAD);
        it.slot = 4'd15;
      end
      default: it = rand_item(walk_busy ? ACT_UNUSED : ibmw_pkg::ACT_REPLY);
    endcase
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] log_blk, input logic [31:0] vol);
    wait_drained();
    write_reg(ibmw_pkg::REG_LOG_BLOCK_SIZE, {29'd0, log_blk});
    write_reg(ibmw_pkg::REG_VOLUME_BLOCKS, vol);
    cur_log = log_blk;
    cur_vol = vol;
  endtask

  // one lookup, mostly carried to its end, with noise and cut-offs mixed in
  task automatic random_walk();
    int unsigned r;
    int unsigned depth;
    bit cut;
    r = $urandom_range(0, 99);
    depth = (r < 15) ? 0 : (r < 40) ? 1 : (r < 65) ? 2 : (r < 90) ? 3 : 4;
    send_resolve(index_for_depth(depth));
    cut = 1'b0;
    while (walk_busy && !cut) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_noise();
      end else if (r < 6) begin
        send_load(4'($urandom_range(0, 15)), ptr_word());
      end else if (r < 9) begin
        cut = 1'b1;
      end else if (levels_left == 0) begin
        send_reply(($urandom_range(0, 6) == 0) ? 32'd0 : $urandom);
      end else begin
        send_reply(ptr_word());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_resolve(64'd0);
    send_resolve(ibmw_pkg::DIRECT_COUNT);
    send_reply($urandom);
    send_item(rand_item(ACT_UNUSED));
  endtask

  task automatic test_direct();
    set_config(3'd0, 32'd1000);
    send_load(4'd0, 32'hFFFF_FFFF);
    send_load(4'(ibmw_pkg::DIRECT_COUNT - 1), 32'd5);
    send_load(4'd15, 32'd77);
    send_load(4'(ibmw_pkg::DIRECT_COUNT), 32'd100);
    send_load(4'(ibmw_pkg::DIRECT_COUNT + 1), 32'd200);
    send_load(4'(ibmw_pkg::DIRECT_COUNT + 2), 32'd300);
    send_resolve(64'd0);
    send_resolve(ibmw_pkg::DIRECT_COUNT - 1);
    send_resolve(64'd3);
  endtask

  task automatic test_indirect();
    send_resolve(ibmw_pkg::DIRECT_COUNT);
    send_reply(32'd7);
    send_resolve(ibmw_pkg::DIRECT_COUNT + 256 + 5 * 256 + 3);
    send_reply(32'd0);
    send_resolve(ibmw_pkg::DIRECT_COUNT + 256 + 65536);
    send_reply(32'd1);
    send_reply(32'd1000);
    send_resolve(ibmw_pkg::DIRECT_COUNT + 256 + 65536 + (64'd1 << 24));
    send_resolve(FB_MAX);
    // a new lookup drops the pending one; the late reply is ignored
    send_resolve(ibmw_pkg::DIRECT_COUNT + 1);
    send_resolve(64'd3);
    send_reply(32'd9);
  endtask

  task automatic test_clamped_log();
    set_config(3'd7, 32'hFFFF_FFFF);
    send_resolve(ibmw_pkg::DIRECT_COUNT + (64'd1 << 14) - 1);
    send_reply(32'hFFFF_FFFF);
  endtask

  task automatic test_random();
    logic [2:0]  logs [PHASES];
    logic [31:0] vols [PHASES];
    int unsigned r;
    logs = '{3'd0, 3'd7, 3'd6, 3'($urandom), 3'd2, 3'($urandom)};
    vols = '{32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, $urandom_range(5000, 2), 32'd0,
             $urandom};
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(logs[ph], vols[ph]);
      for (int s = ibmw_pkg::DIRECT_COUNT; s < TABLE_SLOTS; s++) begin
        send_load(4'(s), ptr_word());
      end
      useful_count = 0;
      while (useful_count < RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 72) random_walk();
        else if (r < 86) send_load(4'($urandom_range(0, 15)),
                                   $urandom_range(0, 1) ? ptr_word() : $urandom);
        else if (r < 98) send_noise();
        else wait_drained();
      end
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) random_walk();
    tx_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) random_walk();
    wait_drained();
    for (int i = 0; i < 20; i++) random_walk();
  endtask

  // ---------------------------------------------------------------- processes

  // result side: random stalls in noisy stretches, plus one long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned seg_left;
    bit noisy;
    stall_left = 0;
    seg_left = 0;
    noisy = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        noisy = $urandom_range(0, 2) != 0;
        seg_left = $urandom_range(50, 300);
      end
      seg_left--;
      if (stall_left == 0 && noisy && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    answer_t exp_ans;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (answers.size() == 0) begin
          $error("unexpected result: status %0d addr %h block %h",
                 out_tuser, out_tdata[47:0], out_tdata[79:48]);
          error_count++;
        end else begin
          exp_ans = answers.pop_front();
          if (out_tuser != exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, out_tuser);
            error_count++;
          end
          if (out_tdata[47:0] != exp_ans.read_address) begin
            $error("read_address: expected %h, got %h",
                   exp_ans.read_address, out_tdata[47:0]);
            error_count++;
          end
          if (out_tdata[79:48] != exp_ans.disk_block) begin
            $error("disk_block: expected %h, got %h", exp_ans.disk_block, out_tdata[79:48]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) ptr_table[i] = '0;
    rem_index     = '0;
    levels_left   = 0;
    walk_busy     = 1'b0;
    cur_log       = '0;
    cur_vol       = '0;
    error_count   = 0;
    useful_count  = 0;
    long_hold_req = 1'b0;
    tx_steady     = 1'b0;
    tx_noisy      = 1'b0;
    tx_seg_left   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_direct();
    test_indirect();
    test_clamped_log();
    test_random();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ibmw_pkg.sv
design/ibmw_front.sv
design/ibmw_queue.sv
design/ibmw_back.sv
design/indirect_block_map_walker.sv
sim/indirect_block_map_walker_tb.sv
